// File: hdl/acre_pkg.sv
package acre_pkg;

  // Counter width of the run tracker; the run_length field caps it at 16 bits
  localparam int RUN_BITS = 16;
  localparam int LEN_W    = 16;
  localparam int CNT_W    = (RUN_BITS < LEN_W) ? RUN_BITS : LEN_W;

  localparam int BYTE_W   = 8;
  localparam int IN_DATA_W  = 16;  // ref_byte, query_byte
  localparam int OUT_DATA_W = 24;  // run_length, op_code, zero fill

  localparam logic [BYTE_W-1:0] GAP_BYTE = 8'h2D;  // '-'

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_MATCH    = 2'd0,
    OP_INS      = 2'd1,
    OP_DEL      = 2'd2,
    OP_MISMATCH = 2'd3
  } cigar_op_t;

  // One classified alignment column
  typedef struct packed {
    logic      skip;  // gap in both rows
    cigar_op_t op;
    logic      last;
  } col_class_t;

  typedef struct packed {
    logic [LEN_W-1:0] run_length;
    cigar_op_t        op_code;
    logic             final_run;
  } run_result_t;

  // Up to two results per column, in emission order
  typedef struct packed {
    logic [1:0]  num;
    run_result_t first;
    run_result_t second;
  } queue_push_t;

endpackage

// File: hdl/acre_classify.sv
module acre_classify (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [acre_pkg::BYTE_W-1:0]        ref_byte,
  input  logic [acre_pkg::BYTE_W-1:0]        query_byte,
  input  logic                               end_flag,
  output logic                               col_valid,
  input  logic                               col_take,
  output acre_pkg::col_class_t               col
);
  import acre_pkg::*;

  logic       valid_r, valid_nxt;
  col_class_t col_r, col_nxt;
  logic       rgap, qgap;

  assign rgap     = (ref_byte == GAP_BYTE);
  assign qgap     = (query_byte == GAP_BYTE);
  assign in_ready = !valid_r || col_take;

  always_comb begin
    col_nxt.skip = rgap && qgap;
    col_nxt.last = end_flag;
    if (rgap) begin
      col_nxt.op = OP_DEL;
    end else if (qgap) begin
      col_nxt.op = OP_INS;
    end else if (ref_byte == query_byte) begin
      col_nxt.op = OP_MATCH;
    end else begin
      col_nxt.op = OP_MISMATCH;
    end
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      col_r <= col_nxt;
    end
  end

  assign col_valid = valid_r;
  assign col       = col_r;

endmodule

// File: hdl/acre_run_tracker.sv
module acre_run_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  col_valid,
  input  acre_pkg::col_class_t  col,
  input  logic                  room,
  output logic                  col_take,
  output acre_pkg::queue_push_t push
);
  import acre_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  cigar_op_t        op_r, op_nxt, op_upd;
  logic             close_run, flush;
  run_result_t      closed_res, final_res;

  assign col_take = col_valid && room;

  always_comb begin
    cnt_upd   = cnt_r;
    op_upd    = op_r;
    close_run = 1'b0;
    if (!col.skip) begin
      if (cnt_r == '0) begin
        cnt_upd = CNT_W'(1);
        op_upd  = col.op;
      end else if (col.op != op_r) begin
        close_run = 1'b1;
        cnt_upd   = CNT_W'(1);
        op_upd    = col.op;
      end else if (cnt_r == '1) begin
        // full counter: close the run, restart with the same operation
        close_run = 1'b1;
        cnt_upd   = CNT_W'(1);
      end else begin
        cnt_upd = cnt_r + CNT_W'(1);
      end
    end

    flush = col.last;

    closed_res.run_length = LEN_W'(cnt_r);
    closed_res.op_code    = op_r;
    closed_res.final_run  = 1'b0;

    // empty alignment flushes as count zero, match
    final_res.run_length = LEN_W'(cnt_upd);
    final_res.op_code    = (cnt_upd == '0) ? OP_MATCH : op_upd;
    final_res.final_run  = 1'b1;

    push.num    = col_take ? (2'({1'b0, close_run}) + 2'({1'b0, flush})) : 2'd0;
    push.first  = close_run ? closed_res : final_res;
    push.second = final_res;

    if (flush) begin
      cnt_nxt = '0;
      op_nxt  = OP_MATCH;
    end else begin
      cnt_nxt = cnt_upd;
      op_nxt  = op_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      op_r  <= OP_MATCH;
    end else if (col_take) begin
      cnt_r <= cnt_nxt;
      op_r  <= op_nxt;
    end
  end

endmodule

// File: hdl/acre_out_queue.sv
module acre_out_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  acre_pkg::queue_push_t push,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output acre_pkg::run_result_t out_res
);
  import acre_pkg::*;

  run_result_t       slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign out_res   = slot_r[head_r];
  assign pop       = out_valid && out_ready;
  // a column may bring two results
  assign room      = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    head_nxt  = pop ? head_r + QPTR_W'(1) : head_r;
    tail_nxt  = tail_r + QPTR_W'(push.num);
    count_nxt = count_r + QCNT_W'(push.num) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      slot_r[tail_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      slot_r[tail_r + QPTR_W'(1)] <= push.second;
    end
  end

endmodule

// File: hdl/alignment_cigar_run_encoder.sv
// Path: an accepted column is registered in the classify stage, then its results are
//   written into the result queue, which offers them to the sink.
// Throughput: one column per cycle; results leave at one per cycle while the sink is
//   ready, and a column that closes a run and ends the alignment yields two results.
// The column stage stalls only when the four-entry result queue has fewer than two
//   free slots.
// Reset: synchronous, active low; clears the open run and empties the queue.
module alignment_cigar_run_encoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [acre_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] ref_byte, [15:8] query_byte
  input  logic                                in_tlast,   // end_of_alignment
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [acre_pkg::OUT_DATA_W-1:0]     out_tdata,  // [15:0] run_length, [17:16] op_code
  output logic                                out_tlast   // final_run
);
  import acre_pkg::*;

  logic        col_valid, col_take, room;
  col_class_t  col;
  queue_push_t push;
  run_result_t out_res;

  // Register the column and classify it as match, mismatch, insertion or deletion
  acre_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .ref_byte   (in_tdata[7:0]),
    .query_byte (in_tdata[15:8]),
    .end_flag   (in_tlast),
    .col_valid  (col_valid),
    .col_take   (col_take),
    .col        (col)
  );

  // Extend or close the open run; flush it on end of alignment
  acre_run_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .col_valid (col_valid),
    .col       (col),
    .room      (room),
    .col_take  (col_take),
    .push      (push)
  );

  // Hold results until the sink takes them
  acre_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{(OUT_DATA_W - LEN_W - 2){1'b0}}, out_res.op_code, out_res.run_length};
  assign out_tlast = out_res.final_run;

endmodule

// File: hdl/acre_checker.sv
module acre_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [acre_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic                                out_tlast
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // a stalled word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // a zero-length run only closes an empty alignment
  a_zero_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:0] == 16'd0 |-> out_tlast && out_tdata[17:16] == 2'd0)
    else $error("zero-length run not marked final");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

endmodule

bind alignment_cigar_run_encoder acre_checker u_acre_checker (.*);

// File: sim/alignment_cigar_run_encoder_test.sv
`timescale 1ns / 100ps

module alignment_cigar_run_encoder_test;
  import acre_pkg::*;

  // Longest run the counter holds before it has to split; the 16-bit length field caps it
  localparam int RUN_CAP = (RUN_BITS >= LEN_W) ? 65535 : (1 << RUN_BITS) - 1;

  localparam int RANDOM_COLS = 1250;  // counted columns in the random part
  localparam int CALM_COLS   = 200;   // closing stretch with no idling on either side
  localparam int STALL_MAX   = 13;    // longest idle burst, either side
  localparam int QUIET_LIMIT = 3000;  // cycles with no word moved before giving up
  localparam int SETTLE      = 8;     // hold-off after the last result
  localparam int PRINT_MAX   = 40;    // keep the log short on a badly broken block
  localparam int PREDICT     = -1;    // plan row checked against the predictor

  localparam logic [7:0] BASES [4] = '{"A", "C", "G", "T"};
  localparam run_result_t NO_RUN = '0;

  // One row of the directed plan: a column repeated reps times, end flag on the
  // last repetition only.  n_fixed says how many of e0/e1 are the written-down
  // answer; PREDICT leaves the row to the predictor.
  typedef struct packed {
    logic [7:0]  rb;
    logic [7:0]  qb;
    logic        eoa;
    int          reps;
    int          n_fixed;
    run_result_t e0;
    run_result_t e1;
  } plan_row_t;

  localparam int PLAN_LEN = 18;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // empty alignment straight after reset: a lone gap pair with the end flag
    '{GAP_BYTE, GAP_BYTE, 1'b1, 1, 1, '{16'd0, OP_MATCH, 1'b1}, NO_RUN},
    // walk through every operation in turn
    '{"A", "A", 1'b0, 1, PREDICT, NO_RUN, NO_RUN},
    '{"A", "T", 1'b0, 1, PREDICT, NO_RUN, NO_RUN},
    '{GAP_BYTE, "G", 1'b0, 1, PREDICT, NO_RUN, NO_RUN},
    '{"C", GAP_BYTE, 1'b0, 1, PREDICT, NO_RUN, NO_RUN},
    '{GAP_BYTE, GAP_BYTE, 1'b0, 1, PREDICT, NO_RUN, NO_RUN},
    '{"C", GAP_BYTE, 1'b1, 1, 1, '{16'd2, OP_INS, 1'b1}, NO_RUN},
    // byte extremes
    '{8'h00, 8'h00, 1'b1, 1, 1, '{16'd1, OP_MATCH, 1'b1}, NO_RUN},
    '{8'hFF, 8'h00, 1'b0, 1, PREDICT, NO_RUN, NO_RUN},
    '{8'h00, 8'hFF, 1'b1, 1, 1, '{16'd2, OP_MISMATCH, 1'b1}, NO_RUN},
    '{8'hFF, 8'hFF, 1'b0, 1, PREDICT, NO_RUN, NO_RUN},
    '{8'hFF, GAP_BYTE, 1'b1, 1, 2, '{16'd1, OP_MATCH, 1'b0}, '{16'd1, OP_INS, 1'b1}},
    // a skipped end column still flushes the open run
    '{GAP_BYTE, 8'hFF, 1'b0, 1, PREDICT, NO_RUN, NO_RUN},
    '{GAP_BYTE, GAP_BYTE, 1'b1, 1, 1, '{16'd1, OP_DEL, 1'b1}, NO_RUN},
    // all-gap alignment of two columns
    '{GAP_BYTE, GAP_BYTE, 1'b0, 1, PREDICT, NO_RUN, NO_RUN},
    '{GAP_BYTE, GAP_BYTE, 1'b1, 1, 1, '{16'd0, OP_MATCH, 1'b1}, NO_RUN},
    // neighbours of the gap byte are ordinary characters
    '{8'h2C, 8'h2E, 1'b0, 1, PREDICT, NO_RUN, NO_RUN},
    '{8'h2E, 8'h2E, 1'b1, 1, PREDICT, NO_RUN, NO_RUN}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset and the ports of the block; every input known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [7:0] ref_byte, [15:8] query_byte
  logic                  in_tlast   = 1'b0; // end_of_alignment
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [15:0] run_length, [17:16] op_code
  logic                  out_tlast;         // final_run

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alignment_cigar_run_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Run tracker mirror and the runs still owed by the block
  // ---------------------------------------------------------------------------
  int          open_len = 0;       // 0 means no open run
  cigar_op_t   open_op  = OP_MATCH;
  run_result_t runs_due [$];

  int errors       = 0;
  int counted_cols = 0;  // columns that are not skipped gap pairs, or that end an alignment
  int alignments   = 0;
  int runs_checked = 0;
  int longest      = 0;
  bit idle_ok      = 1'b1;  // idle bursts allowed on both sides
  bit calm         = 1'b0;  // closing stretch: no idling at all

  // Push a run that the block owes, unless the row writes its own answer
  function automatic void owe_run(bit keep, int len, cigar_op_t op, logic fin);
    run_result_t r;
    r.run_length = len[LEN_W-1:0];
    r.op_code    = op;
    r.final_run  = fin;
    if (keep) runs_due.push_back(r);
  endfunction

  // Classify one accepted column and advance the run tracker
  function automatic void tally_column(logic [7:0] r, logic [7:0] q, logic last, bit keep);
    cigar_op_t op;
    bit        r_gap;
    bit        q_gap;
    r_gap = (r == GAP_BYTE);
    q_gap = (q == GAP_BYTE);
    if (!(r_gap && q_gap)) begin
      if (r_gap)       op = OP_DEL;
      else if (q_gap)  op = OP_INS;
      else if (r == q) op = OP_MATCH;
      else             op = OP_MISMATCH;

      if (open_len == 0) begin
        open_len = 1;
        open_op  = op;
      end else if (op != open_op) begin
        owe_run(keep, open_len, open_op, 1'b0);
        open_len = 1;
        open_op  = op;
      end else if (open_len >= RUN_CAP) begin
        // counter full: close the run, start again with the same operation
        owe_run(keep, open_len, open_op, 1'b0);
        open_len = 1;
      end else begin
        open_len++;
      end
    end

    if (last) begin
      // an alignment of nothing but gap pairs still yields one empty final run
      if (open_len > 0) owe_run(keep, open_len, open_op, 1'b1);
      else              owe_run(keep, 0, OP_MATCH, 1'b1);
      open_len = 0;
      open_op  = OP_MATCH;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= PRINT_MAX)
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Column sender: idle burst first if allowed, then hold the word until taken
  // ---------------------------------------------------------------------------
  task automatic send_column(input logic [7:0] r, input logic [7:0] q, input logic last,
                             input bit predicted);
    int gap;
    if (idle_ok && !calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, STALL_MAX);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {q, r};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tally_column(r, q, last, predicted);
    if (!(r == GAP_BYTE && q == GAP_BYTE) || last) counted_cols++;
    if (last) alignments++;
  endtask

  // Drop valid and hold off until every owed run has come out
  task automatic drain_runs();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (runs_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_base();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) begin
      b = BASES[$urandom_range(0, 3)];
    end else begin
      b = 8'($urandom);
      if (b == GAP_BYTE) b = b ^ 8'h01;
    end
    return b;
  endfunction

  // Build a column that the block should classify as op
  task automatic make_column(input cigar_op_t op, output logic [7:0] r, output logic [7:0] q);
    case (op)
      OP_MATCH: begin
        r = pick_base();
        q = r;
      end
      OP_INS: begin
        r = pick_base();
        q = GAP_BYTE;
      end
      OP_DEL: begin
        r = GAP_BYTE;
        q = pick_base();
      end
      default: begin
        r = pick_base();
        q = pick_base();
        if (q == r) q = ((r ^ 8'h20) == GAP_BYTE) ? (r ^ 8'h40) : (r ^ 8'h20);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: directed plan, then random alignments, then the closing drain
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         row;
    int         k;
    int         j;
    int         len;
    int         run;
    int         shape;
    int         stop_at;
    int         batch;
    cigar_op_t  op;
    logic [7:0] r;
    logic [7:0] q;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan, written-down answers where the row has them
    for (row = 0; row < PLAN_LEN; row++) begin
      for (k = 0; k < PLAN[row].reps; k++)
        send_column(PLAN[row].rb, PLAN[row].qb, PLAN[row].eoa && (k == PLAN[row].reps - 1),
                    PLAN[row].n_fixed == PREDICT);
      if (PLAN[row].n_fixed >= 1) runs_due.push_back(PLAN[row].e0);
      if (PLAN[row].n_fixed >= 2) runs_due.push_back(PLAN[row].e1);
    end

    // let the block run dry once before the random part
    drain_runs();

    stop_at = counted_cols + RANDOM_COLS;
    batch   = 0;
    while (counted_cols < stop_at) begin
      batch++;
      calm = (counted_cols >= stop_at - CALM_COLS);
      if (batch % 16 == 0) idle_ok = ($urandom_range(0, 3) != 0);
      if (batch % 97 == 0) drain_runs();

      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        // noise: any bytes, end flag wherever it lands
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          r = ($urandom_range(0, 4) == 0) ? GAP_BYTE : 8'($urandom);
          q = ($urandom_range(0, 4) == 0) ? GAP_BYTE : 8'($urandom);
          send_column(r, q, $urandom_range(0, 3) == 0, 1'b1);
        end
      end else if (shape == 1) begin
        // broken alignment: gap pairs, maybe a short run, closed by a gap pair
        len = $urandom_range(0, 3);
        for (k = 0; k < len; k++) send_column(GAP_BYTE, GAP_BYTE, 1'b0, 1'b1);
        if ($urandom_range(0, 1) == 1) begin
          op  = cigar_op_t'($urandom_range(0, 3));
          len = $urandom_range(1, 4);
          for (k = 0; k < len; k++) begin
            make_column(op, r, q);
            send_column(r, q, 1'b0, 1'b1);
          end
        end
        send_column(GAP_BYTE, GAP_BYTE, 1'b1, 1'b1);
      end else begin
        // well-formed alignment built from short runs, a stray gap pair here and there
        len = $urandom_range(1, 24);
        k   = 0;
        while (k < len) begin
          op  = cigar_op_t'($urandom_range(0, 3));
          run = $urandom_range(1, 6);
          for (j = 0; j < run && k < len; j++) begin
            if ($urandom_range(0, 11) == 0) begin
              r = GAP_BYTE;
              q = GAP_BYTE;
            end else begin
              make_column(op, r, q);
            end
            send_column(r, q, k == len - 1, 1'b1);
            k++;
          end
        end
      end
    end

    // close any alignment left open so the last run comes out
    if (open_len > 0) send_column(GAP_BYTE, GAP_BYTE, 1'b1, 1'b1);

    calm = 1'b1;
    drain_runs();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d columns over %0d alignments; %0d runs compared field by field.",
             counted_cols, alignments, runs_checked);
    $display("Longest run seen %0d columns against a counter cap of %0d.", longest, RUN_CAP);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure bursts, check each word against the
  // oldest owed run
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    run_result_t want;
    int          got_len;
    int          got_op;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_ok && !calm && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, STALL_MAX) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end

    if (rst_n && out_tvalid && out_tready) begin
      got_len = int'(out_tdata[15:0]);
      got_op  = int'(out_tdata[17:16]);
      if (got_len > longest) longest = got_len;
      if (runs_due.size() == 0) begin
        report_mismatch("run with nothing owed, run_length", got_len, -1);
      end else begin
        want = runs_due.pop_front();
        runs_checked++;
        if (got_len != int'(want.run_length))
          report_mismatch("run_length", got_len, int'(want.run_length));
        if (got_op != int'(want.op_code))
          report_mismatch("op_code", got_op, int'(want.op_code));
        if (out_tlast != want.final_run)
          report_mismatch("final_run", int'(out_tlast), int'(want.final_run));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: give up once no word has moved on either side for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles with no word moved, %0d runs still owed.",
               quiet_cycles, runs_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
